// File: sv/sds_pkg.sv
`timescale 1ns / 1ps

package sds_pkg;

   // fixed register and result widths
   localparam int START_BITS    = 16;
   localparam int DISK_BITS     = 17;
   localparam int CSR_DATA_BITS = 17;
   localparam int SEEK_BITS     = 22;

   localparam logic [SEEK_BITS-1:0] SEEK_MAX = 22'd4194303;

   localparam logic [DISK_BITS-1:0] DISK_TRACKS_RESET = 17'd65536;

   typedef enum logic [1:0] {
      CSR_START_TRACK = 2'd0,
      CSR_DISK_TRACKS = 2'd1,
      CSR_SWEEP_RIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_SCAN    = 3'b010,
      ST_PICK    = 3'b100
   } state_type;

endpackage

// File: sv/sds_ram.sv
`timescale 1ns / 1ps

module sds_ram #(
   parameter int WIDTH     = 16,
   parameter int DEPTH     = 32,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// requests transfer in at one per cycle while the batch is collected into the request ram
// after the last request each visit costs one pass over the ram, which holds the n stored requests
// two more passes close the two sweeps
// a result is offered once the next visit is chosen or the batch ends, later if results stall
// no request is taken until the final result is loaded; then the next batch may start
// synchronous active-high reset clears control state and loads the register reset values
module scan_disk_scheduler_unit #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [TRACK_BITS-1:0]              req_request_track,
   input  logic                               req_last_request,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [TRACK_BITS-1:0]              rsp_visit_track,
   output logic [sds_pkg::SEEK_BITS-1:0]      rsp_seek_total,
   output logic                               rsp_overflowed,
   output logic                               rsp_last_visit,
   // register writes
   input  logic                               csr_we,
   input  sds_pkg::csr_index_type             csr_index,
   input  logic [sds_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import sds_pkg::*;

   // index and count need room for the count itself; the extra code marks the end track
   localparam int IDX_W  = $clog2(MAX_REQUESTS + 1);
   localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int KEY_W  = TRACK_BITS + IDX_W;
   localparam int EW     = (TRACK_BITS > DISK_BITS) ? TRACK_BITS : DISK_BITS;
   localparam int SUM_W  = ((TRACK_BITS > SEEK_BITS) ? TRACK_BITS : SEEK_BITS) + 1;

   localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(MAX_REQUESTS);
   localparam logic [IDX_W-1:0] VIRT_IDX  = IDX_W'(MAX_REQUESTS);

   // configuration registers
   logic [START_BITS-1:0] start_ff;
   logic [DISK_BITS-1:0]  disk_ff;
   logic                  right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         disk_ff  <= DISK_TRACKS_RESET;
         right_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_TRACK: start_ff <= csr_wdata[START_BITS-1:0];
            CSR_DISK_TRACKS: disk_ff  <= csr_wdata[DISK_BITS-1:0];
            CSR_SWEEP_RIGHT: right_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // start head and end track of a rightward sweep (zero size acts as one track)
   logic [TRACK_BITS-1:0] head0;
   logic [DISK_BITS-1:0]  tracks_eff;
   logic [EW-1:0]         end_wide;
   logic [TRACK_BITS-1:0] end_track;

   assign head0      = TRACK_BITS'(start_ff);
   assign tracks_eff = (disk_ff == '0) ? DISK_BITS'(1) : disk_ff;
   assign end_wide   = EW'(tracks_eff - DISK_BITS'(1));
   assign end_track  = (end_wide > EW'({TRACK_BITS{1'b1}})) ? {TRACK_BITS{1'b1}}
                                                            : TRACK_BITS'(end_wide);

   // control state
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  phase_ff, phase_in;     // 0 first sweep, 1 after reversal
   logic                  first_ff, first_in;     // no visit yet in this sweep
   logic                  have_pend_ff, have_pend_in;
   logic                  best_found_ff, best_found_in;
   logic [KEY_W-1:0]      best_key_ff, best_key_in;
   logic [KEY_W-1:0]      prev_key_ff, prev_key_in;
   // head_now and seek_ff also hold the visit waiting for its last flag
   logic [TRACK_BITS-1:0] head_now_ff, head_now_in;
   logic [SEEK_BITS-1:0]  seek_ff, seek_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRACK_BITS-1:0] rsp_visit_ff, rsp_visit_in;
   logic [SEEK_BITS-1:0]  rsp_seek_ff, rsp_seek_in;
   logic                  rsp_over_ff, rsp_over_in;
   logic                  rsp_last_ff, rsp_last_in;

   // request ram
   logic                  mem_we;
   logic                  rd_issue;
   logic [TRACK_BITS-1:0] rd_data;

   sds_ram #(
      .WIDTH (TRACK_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_request_track),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // ascending while sweeping toward high tracks
   logic                  asc;
   logic [TRACK_BITS-1:0] virt_val;
   logic [KEY_W-1:0]      virt_key;
   logic                  virt_ok;
   logic [KEY_W-1:0]      cand_key;
   logic                  cand_side;
   logic                  cand_ok;
   logic                  cand_better;

   assign asc      = right_ff ^ phase_ff;
   assign virt_val = right_ff ? end_track : '0;
   assign virt_key = {virt_val, VIRT_IDX};
   // the end track only joins the first sweep
   assign virt_ok  = !phase_ff &&
                     (first_ff || (asc ? (virt_key > prev_key_ff) : (virt_key < prev_key_ff)));

   // keys order duplicates by store index, so each copy is visited once
   assign cand_key    = {rd_data, rd_idx_ff};
   assign cand_side   = asc ? (rd_data > head0) : (rd_data < head0);
   assign cand_ok     = cand_side &&
                        (first_ff || (asc ? (cand_key > prev_key_ff) : (cand_key < prev_key_ff)));
   assign cand_better = !best_found_ff ||
                        (asc ? (cand_key < best_key_ff) : (cand_key > best_key_ff));

   // seek distance to the chosen track, saturating
   logic [TRACK_BITS-1:0] best_val;
   logic [TRACK_BITS-1:0] seek_step;
   logic [SUM_W-1:0]      sum_w;
   logic [SEEK_BITS-1:0]  seek_next;

   assign best_val  = best_key_ff[KEY_W-1:IDX_W];
   assign seek_step = (best_val > head_now_ff) ? (best_val - head_now_ff)
                                               : (head_now_ff - best_val);
   assign sum_w     = SUM_W'(seek_ff) + SUM_W'(seek_step);
   assign seek_next = (sum_w > SUM_W'(SEEK_MAX)) ? SEEK_MAX : SEEK_BITS'(sum_w);

   logic out_free;
   logic push;
   logic push_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_COLLECT);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      scan_idx_in   = scan_idx_ff;
      phase_in      = phase_ff;
      first_in      = first_ff;
      have_pend_in  = have_pend_ff;
      best_found_in = best_found_ff;
      best_key_in   = best_key_ff;
      prev_key_in   = prev_key_ff;
      head_now_in   = head_now_ff;
      seek_in       = seek_ff;
      mem_we        = 1'b0;
      rd_issue      = 1'b0;
      push          = 1'b0;
      push_last     = 1'b0;

      case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               if (count_ff < COUNT_MAX) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + IDX_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_request) begin
                  state_in     = ST_SCAN;
                  phase_in     = 1'b0;
                  first_in     = 1'b1;
                  have_pend_in = 1'b0;
                  head_now_in  = head0;
                  seek_in      = '0;
                  scan_idx_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            // first cycle of a pass seeds the best with the end track
            if (scan_idx_ff == '0 && !rd_pend_ff) begin
               best_found_in = virt_ok;
               best_key_in   = virt_key;
            end
            if (rd_pend_ff && cand_ok && cand_better) begin
               best_found_in = 1'b1;
               best_key_in   = cand_key;
            end
            if (scan_idx_ff < count_ff) begin
               rd_issue    = 1'b1;
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
            if (scan_idx_ff == count_ff && !rd_pend_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (best_found_ff) begin
               // the waiting visit goes out now that another one follows
               if (!have_pend_ff || out_free) begin
                  push         = have_pend_ff;
                  head_now_in  = best_val;
                  seek_in      = seek_next;
                  prev_key_in  = best_key_ff;
                  first_in     = 1'b0;
                  have_pend_in = 1'b1;
                  scan_idx_in  = '0;
                  state_in     = ST_SCAN;
               end
            end else if (!phase_ff) begin
               // reverse the sweep
               phase_in    = 1'b1;
               first_in    = 1'b1;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end else if (out_free) begin
               push         = 1'b1;
               push_last    = 1'b1;
               have_pend_in = 1'b0;
               count_in     = '0;
               drop_in      = 1'b0;
               seek_in      = '0;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      rd_pend_in = rd_issue;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_visit_in = rsp_visit_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_visit_in = head_now_ff;
         rsp_seek_in  = seek_ff;
         rsp_over_in  = drop_ff;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         scan_idx_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         phase_ff      <= 1'b0;
         first_ff      <= 1'b1;
         have_pend_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         head_now_ff   <= '0;
         seek_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         scan_idx_ff   <= scan_idx_in;
         rd_pend_ff    <= rd_pend_in;
         phase_ff      <= phase_in;
         first_ff      <= first_in;
         have_pend_ff  <= have_pend_in;
         best_found_ff <= best_found_in;
         head_now_ff   <= head_now_in;
         seek_ff       <= seek_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= scan_idx_ff;
      best_key_ff  <= best_key_in;
      prev_key_ff  <= prev_key_in;
      rsp_visit_ff <= rsp_visit_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_visit_track = rsp_visit_ff;
   assign rsp_seek_total  = rsp_seek_ff;
   assign rsp_overflowed  = rsp_over_ff;
   assign rsp_last_visit  = rsp_last_ff;

   // all reads of a pass are folded in before a visit is chosen
   a_pick_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> !rd_pend_ff)
      else $error("visit chosen with a ram read outstanding");

   // requests are only dropped once the store is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (count_ff == COUNT_MAX))
      else $error("drop flag set with room in the store");

   // final transfer ends the batch and empties the store
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      push_last |=> (state_ff == ST_COLLECT) && (count_ff == '0) && !drop_ff)
      else $error("batch not closed after final result");

   // no visit is left waiting while requests are collected
   a_no_stale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT) |-> !have_pend_ff)
      else $error("pending visit while collecting");

endmodule

// File: dv/scan_order_checker.sv
`timescale 1ns / 1ps

module scan_order_checker #(
   parameter int MAX_REQUESTS = 32,
   parameter int TRACK_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [TRACK_BITS-1:0]              req_request_track,
   input  logic                               req_last_request,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [TRACK_BITS-1:0]              rsp_visit_track,
   input  logic [sds_pkg::SEEK_BITS-1:0]      rsp_seek_total,
   input  logic                               rsp_overflowed,
   input  logic                               rsp_last_visit,
   input  logic                               csr_we,
   input  sds_pkg::csr_index_type             csr_index,
   input  logic [sds_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   import sds_pkg::*;

   typedef struct packed {
      logic [TRACK_BITS-1:0] track;
      logic [SEEK_BITS-1:0]  seek;
      logic                  overflow;
      logic                  last;
   } visit_rec_type;

   localparam int TRACK_TOP   = (1 << TRACK_BITS) - 1;

   logic [TRACK_BITS-1:0] queued_tracks [MAX_REQUESTS];
   int                    queued_count;
   logic                  dropped_any;
   logic [TRACK_BITS-1:0] head_start;
   logic [DISK_BITS-1:0]  tracks_cfg;
   logic                  sweep_up;
   visit_rec_type         planned_visits [$];
   int                    mismatch_count = 0;
   int                    visits_seen = 0;

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ns visit %0d: %s", $time, visits_seen, msg);
   endtask

   // keys order the whole visit sequence: top bit picks the sweep,
   // tracks below the head are inverted so they come out descending
   task automatic plan_scan_order();
      logic [TRACK_BITS:0]   order_keys [MAX_REQUESTS+1];
      logic [TRACK_BITS:0]   key;
      logic [TRACK_BITS-1:0] track;
      logic [TRACK_BITS-1:0] head;
      logic [TRACK_BITS-1:0] end_trk;
      int                    n;
      int                    i;
      int                    j;
      int                    seek;
      int                    hop;
      visit_rec_type         rec;
      n = 0;
      head = head_start;
      if (sweep_up) begin
         if (tracks_cfg == 0) end_trk = '0;
         else if (int'(tracks_cfg) - 1 > TRACK_TOP) end_trk = '1;
         else end_trk = TRACK_BITS'(int'(tracks_cfg) - 1);
         order_keys[n] = {1'b0, end_trk};
      end else begin
         order_keys[n] = {1'b0, {TRACK_BITS{1'b1}}};
      end
      n++;
      for (i = 0; i < queued_count; i++) begin
         track = queued_tracks[i];
         if (track < head) begin
            order_keys[n] = {sweep_up, ~track};
            n++;
         end else if (track > head) begin
            order_keys[n] = {~sweep_up, track};
            n++;
         end
      end
      for (i = 1; i < n; i++) begin
         key = order_keys[i];
         j = i - 1;
         while (j >= 0 && order_keys[j] > key) begin
            order_keys[j+1] = order_keys[j];
            j--;
         end
         order_keys[j+1] = key;
      end
      seek = 0;
      for (i = 0; i < n; i++) begin
         key = order_keys[i];
         track = (key[TRACK_BITS] == sweep_up) ? ~key[TRACK_BITS-1:0] : key[TRACK_BITS-1:0];
         hop = (track > head) ? int'(track) - int'(head) : int'(head) - int'(track);
         seek = seek + hop;
         if (seek > int'(SEEK_MAX)) seek = int'(SEEK_MAX);
         head = track;
         rec.track = track;
         rec.seek = SEEK_BITS'(seek);
         rec.overflow = dropped_any;
         rec.last = (i == n - 1);
         planned_visits = {planned_visits, rec};
      end
   endtask

   always @(posedge clock) begin
      visit_rec_type want;
      if (reset) begin
         queued_count = 0;
         dropped_any = 1'b0;
         head_start = '0;
         tracks_cfg = DISK_TRACKS_RESET;
         sweep_up = 1'b0;
         planned_visits.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_TRACK: head_start = csr_wdata[TRACK_BITS-1:0];
               CSR_DISK_TRACKS: tracks_cfg = csr_wdata[DISK_BITS-1:0];
               CSR_SWEEP_RIGHT: sweep_up = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (planned_visits.size() == 0) begin
               flag_mismatch($sformatf("unplanned visit to track %0d", rsp_visit_track));
            end else begin
               want = planned_visits.pop_front();
               if (rsp_visit_track !== want.track)
                  flag_mismatch($sformatf("visit_track %0d, expected %0d",
                                          rsp_visit_track, want.track));
               if (rsp_seek_total !== want.seek)
                  flag_mismatch($sformatf("seek_total %0d, expected %0d",
                                          rsp_seek_total, want.seek));
               if (rsp_overflowed !== want.overflow)
                  flag_mismatch($sformatf("overflowed %0b, expected %0b",
                                          rsp_overflowed, want.overflow));
               if (rsp_last_visit !== want.last)
                  flag_mismatch($sformatf("last_visit %0b, expected %0b",
                                          rsp_last_visit, want.last));
            end
            visits_seen++;
         end
         if (req_valid && req_ready) begin
            if (queued_count < MAX_REQUESTS) begin
               queued_tracks[queued_count] = req_request_track;
               queued_count++;
            end else begin
               dropped_any = 1'b1;
            end
            if (req_last_request) begin
               plan_scan_order();
               queued_count = 0;
               dropped_any = 1'b0;
            end
         end
      end
      mismatches <= mismatch_count;
      outstanding <= planned_visits.size();
   end

endmodule

// File: dv/tb_scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_scan_disk_scheduler_unit;

   import sds_pkg::*;

   localparam int MAX_REQUESTS  = 32;
   localparam int TRACK_BITS    = 16;
   // quiet gap after the final result before anything else is driven
   localparam int SETTLE_CYCLES = 80;
   // receiver hold-off long enough for a full batch to back up into the input
   localparam int HOLD_CYCLES   = 300;
   // worst legal quiet stretch is the hold-off plus one slow turnaround scan
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 25;
   localparam logic [1:0] CSR_INDEX_UNUSED = 2'd3;

   // clock and reset, all block inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [TRACK_BITS-1:0]       req_request_track = '0;
   logic                        req_last_request = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [TRACK_BITS-1:0]       rsp_visit_track;
   logic [SEEK_BITS-1:0]        rsp_seek_total;
   logic                        rsp_overflowed;
   logic                        rsp_last_visit;
   logic                        csr_we = 1'b0;
   csr_index_type               csr_index = CSR_START_TRACK;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   int mismatches;
   int outstanding;

   // idling knobs, percent of cycles
   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_results = 1'b0;

   // register values as last written, used to aim requests at interesting tracks
   logic [TRACK_BITS-1:0] cur_start = '0;
   int                    cur_tracks = 65536;

   int requests_sent = 0;
   int batches_sent = 0;
   int overflow_batches = 0;
   int settings_applied = 0;

   always #1 clock = ~clock;

   scan_disk_scheduler_unit #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .TRACK_BITS   (TRACK_BITS)
   ) DUT (.*);

   scan_order_checker #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .TRACK_BITS   (TRACK_BITS)
   ) checker_i (.*);

   // one request transfer, with a random idle gap in front of it;
   // valid stays high on return so back-to-back transfers need no toggle
   task automatic send_request(input logic [TRACK_BITS-1:0] track, input logic last);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_request_track <= track;
      req_last_request <= last;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      if (last) batches_sent++;
   endtask

   // stop offering and wait for every planned visit, then let the block go idle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all three registers, plus a write to the unused index that must be ignored;
   // spare data bits are filled with noise since the block should mask them
   task automatic configure(input logic [TRACK_BITS-1:0] start, input logic [16:0] tracks,
                            input logic right);
      logic [16:0] noise;
      noise = 17'($urandom);
      csr_we <= 1'b1;
      csr_index <= CSR_START_TRACK;
      csr_wdata <= {noise[16], start};
      @(posedge clock);
      csr_index <= CSR_DISK_TRACKS;
      csr_wdata <= tracks;
      @(posedge clock);
      csr_index <= CSR_SWEEP_RIGHT;
      csr_wdata <= {noise[15:0], right};
      @(posedge clock);
      csr_index <= csr_index_type'(CSR_INDEX_UNUSED);
      csr_wdata <= ~noise;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_start = start;
      cur_tracks = int'(tracks);
      settings_applied++;
   endtask

   // one batch with random content: tracks at the start, at the disk ends,
   // repeats of the previous one, inside the disk and anywhere in range
   task automatic run_batch(input int size);
      logic [TRACK_BITS-1:0] track;
      logic [TRACK_BITS-1:0] prev;
      int                    end_trk;
      end_trk = (cur_tracks == 0) ? 0 : cur_tracks - 1;
      if (end_trk > 65535) end_trk = 65535;
      prev = cur_start;
      if (size > MAX_REQUESTS) overflow_batches++;
      for (int i = 0; i < size; i++) begin
         case ($urandom_range(0, 9))
            0:       track = cur_start;
            1:       track = '0;
            2:       track = '1;
            3:       track = TRACK_BITS'(end_trk);
            4:       track = prev;
            5, 6:    track = TRACK_BITS'($urandom_range(0, 65535));
            default: track = TRACK_BITS'($urandom_range(0, end_trk));
         endcase
         send_request(track, i == size - 1);
         prev = track;
      end
   endtask

   // result side: random stalls, or one long hold-off counted here
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // ends the run if neither channel moves a transfer for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("tb_scan_disk_scheduler_unit failed");
      $finish;
   end

   initial begin : stimulus
      logic [TRACK_BITS-1:0] new_start;
      int                    new_tracks;
      int                    phase_end;
      int                    batch_size;
      int                    top_trk;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed batches, no idling
      // reset settings: head at 0 sweeping down, request on the head skipped,
      // a duplicate pair, both track extremes
      send_request(16'd0, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'h8000, 1'b1);
      drain();
      // sweep up on a small disk: request on the end track, beyond the disk, below the head
      configure(16'd100, 17'd200, 1'b1);
      send_request(16'd100, 1'b0);
      send_request(16'd199, 1'b0);
      send_request(16'd150, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd50, 1'b1);
      drain();
      // zero disk size acts as one track; only request sits on the head
      configure(16'hFFFF, 17'd0, 1'b1);
      send_request(16'hFFFF, 1'b1);
      drain();
      // disk larger than the track range: end track saturates
      configure(16'd5, 17'h1FFFF, 1'b1);
      send_request(16'd0, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd6, 1'b0);
      send_request(16'd4, 1'b1);
      drain();
      // one-track disk, head already on the end track
      configure(16'd0, 17'd1, 1'b0);
      send_request(16'd0, 1'b1);
      drain();
      // mid-disk start sweeping down
      configure(16'd40000, 17'd65536, 1'b0);
      send_request(16'd39999, 1'b0);
      send_request(16'd40001, 1'b0);
      send_request(16'd40000, 1'b0);
      send_request(16'd1, 1'b1);
      drain();

      // backpressure: results held while an overfull batch and the next one are offered,
      // so the block stops taking requests until the hold is released
      configure(16'd30000, 17'd65536, 1'b1);
      hold_results = 1'b1;
      run_batch(MAX_REQUESTS + 2);
      run_batch(4);
      drain();

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct = 58;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct = 0;
               rsp_stall_pct = 58;
            end
            default: begin
               req_idle_pct = 31;
               rsp_stall_pct = 31;
            end
         endcase
         phase_end = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) begin
            // new register settings only with the block idle
            if ($urandom_range(0, 2) == 0) begin
               drain();
               case ($urandom_range(0, 5))
                  0:       new_tracks = 0;
                  1:       new_tracks = 1;
                  2:       new_tracks = 65536;
                  3:       new_tracks = $urandom_range(65537, 131071);
                  default: new_tracks = $urandom_range(2, 4096);
               endcase
               top_trk = (new_tracks <= 1) ? 0 : new_tracks - 1;
               if (top_trk > 65535) top_trk = 65535;
               case ($urandom_range(0, 3))
                  0:       new_start = '0;
                  1:       new_start = '1;
                  2:       new_start = TRACK_BITS'($urandom_range(0, 65535));
                  default: new_start = TRACK_BITS'($urandom_range(0, top_trk));
               endcase
               configure(new_start, 17'(new_tracks), 1'($urandom_range(0, 1)));
            end
            // mostly short batches, some long ones, now and then one that overruns the store
            case ($urandom_range(0, 19))
               0:          batch_size = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
               1, 2, 3:    batch_size = $urandom_range(9, MAX_REQUESTS);
               default:    batch_size = $urandom_range(1, 8);
            endcase
            run_batch(batch_size);
         end
      end

      drain();
      $display("covered %0d requests in %0d batches, %0d of them overrunning the store",
               requests_sent, batches_sent, overflow_batches);
      $display("%0d register settings under four idling mixes and one long result hold",
               settings_applied);
      if (mismatches == 0) begin
         $display("tb_scan_disk_scheduler_unit passed");
      end else begin
         $display("tb_scan_disk_scheduler_unit failed");
      end
      $finish;
   end

endmodule
